// ===== rtl/core/rlcd_pkg.sv =====
// Shared constants, types and the sRGB linearization table for the color distance pipeline.
package rlcd_pkg;

  localparam int DIST_FRAC_BITS = 8;
  localparam int ROUND_SH       = 16 - DIST_FRAC_BITS;
  localparam int OUT_W          = 17;
  localparam logic [OUT_W-1:0] OUT_MAX = 17'd131071;

  localparam int LIN_W  = 17;
  localparam int F_W    = 21;
  localparam int T_W    = 22;
  localparam int NUM_W  = 44;
  localparam int ROOT_W = 29;
  localparam int SUM_W  = 58;
  localparam int E_W    = 28;

  // Cube root step count and the width of the linear-segment numerator.
  localparam int CUBE_STEPS = F_W;
  localparam int LN_W       = 28;

  // Cycles from the linearized register to a valid f value inside a channel.
  localparam int CHAN_LAT = 4 + CUBE_STEPS;

  localparam logic [1:0] CH_X = 2'd0;
  localparam logic [1:0] CH_Y = 2'd1;
  localparam logic [1:0] CH_Z = 2'd2;

  typedef logic [23:0] coef_t;
  typedef coef_t coef_row_t [3];
  typedef coef_row_t coef_mat_t [3];
  typedef coef_t white_t [3];

  localparam coef_mat_t MAT7 = '{
    '{24'd4124564, 24'd3575761, 24'd1804375},
    '{24'd2126729, 24'd7151522, 24'd721750},
    '{24'd193339,  24'd1191920, 24'd9503041}
  };
  localparam white_t WHITE_D    = '{24'd9504700, 24'd10000000, 24'd10888300};
  localparam white_t WHITE_HALF = '{24'd4752350, 24'd5000000,  24'd5444150};

  // Rounded-up reciprocals of the white point. With a numerator below 2^44 and a divisor
  // below 2^24, keeping the product bits from 2^68 up gives the exact floored quotient.
  localparam int RECIP_W  = 45;
  localparam int RECIP_SH = 68;

  function automatic logic [RECIP_W-1:0] white_recip(input logic [23:0] d);
    return RECIP_W'(((72'd1 << RECIP_SH) + 72'(d) - 72'd1) / 72'(d));
  endfunction

  typedef logic [RECIP_W-1:0] recip_t [3];
  localparam recip_t WHITE_RECIP = '{white_recip(WHITE_D[0]), white_recip(WHITE_D[1]),
                                     white_recip(WHITE_D[2])};

  // Cube segment starts at the first Q20 value above the CIE knee.
  localparam logic [T_W-1:0] F_KNEE = 22'd9287;
  localparam logic [13:0] LIN_MUL = 14'd9033;
  localparam logic [27:0] LIN_ADD = 28'd167772740;
  localparam logic [10:0] LIN_DIV = 11'd1160;

  // The linear numerator stays below 2^28, so a 39-bit reciprocal shift is exact.
  localparam int LIN_RECIP_SH = 39;
  localparam logic [28:0] LIN_RECIP =
    29'(((64'd1 << LIN_RECIP_SH) + 64'(LIN_DIV) - 64'd1) / 64'(LIN_DIV));

  typedef logic [LIN_W-1:0] lin_tab_t [256];

  function automatic logic [63:0] pow5_q30(input logic [63:0] r);
    logic [63:0] p;
    p = r;
    for (int k = 0; k < 4; k++) begin
      p = (p * r) >> 30;
    end
    return p;
  endfunction

  function automatic logic [LIN_W-1:0] lin_q16(input logic [63:0] c);
    logic [63:0] tq;
    logic [63:0] t2;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    if (c <= 64'd10) begin
      return LIN_W'((c * 64'd6553600 + 64'd164730) / 64'd329460);
    end
    tq = ((64'd1000 * c + 64'd14025) << 30) / 64'd269025;
    t2 = (tq * tq) >> 30;
    lo = 64'd0;
    hi = 64'd1 << 30;
    for (int n = 0; n < 40; n++) begin
      if (lo < hi) begin
        mid = lo + ((hi - lo + 64'd1) >> 1);
        if (pow5_q30(mid) <= t2) begin
          lo = mid;
        end else begin
          hi = mid - 64'd1;
        end
      end
    end
    return LIN_W'((((t2 * lo) >> 30) + 64'd8192) >> 14);
  endfunction

  function automatic lin_tab_t build_lin_tab();
    lin_tab_t tab;
    for (int c = 0; c < 256; c++) begin
      tab[c] = lin_q16(64'(c));
    end
    return tab;
  endfunction

  localparam lin_tab_t LIN_TAB = build_lin_tab();

endpackage

// ===== rtl/core/rgb_lab_color_distance_top.sv =====
// Top level: CIE76 delta E between two sRGB pixels, fully pipelined.
// Takes one pixel pair per clock while the output is not stalled and returns
// one distance per pair, in order. The depth is set by the bit-serial stages:
// a 21-step cube root and a 29-step square root; white normalization is a
// two-stage reciprocal multiply. A stall on the output freezes the whole
// pipeline, so in_stall follows out_stall whenever a result is waiting. The
// distance is unsigned with 8 fraction bits, saturating at 131071.
module rgb_lab_color_distance_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  first_red,
  input  logic [7:0]  first_green,
  input  logic [7:0]  first_blue,
  input  logic [7:0]  second_red,
  input  logic [7:0]  second_green,
  input  logic [7:0]  second_blue,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [16:0] color_distance
);

  localparam int LW = rlcd_pkg::LIN_W;
  localparam int FW = rlcd_pkg::F_W;
  localparam int EW = rlcd_pkg::E_W;
  localparam int SW = rlcd_pkg::SUM_W;
  localparam int RW = rlcd_pkg::ROOT_W;
  localparam int VN = 1 + rlcd_pkg::CHAN_LAT + 3 + RW;

  logic en;
  assign en = !out_valid || !out_stall;
  assign in_stall = !en;

  logic vpipe [VN];
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < VN; i++) begin
        vpipe[i] <= 1'b0;
      end
      out_valid <= 1'b0;
    end else if (en) begin
      vpipe[0] <= in_valid;
      for (int i = 1; i < VN; i++) begin
        vpipe[i] <= vpipe[i-1];
      end
      out_valid <= vpipe[VN-1];
    end
  end

  logic [LW-1:0] lin [6];
  always_ff @(posedge clk) begin
    if (en) begin
      lin[0] <= rlcd_pkg::LIN_TAB[first_red];
      lin[1] <= rlcd_pkg::LIN_TAB[first_green];
      lin[2] <= rlcd_pkg::LIN_TAB[first_blue];
      lin[3] <= rlcd_pkg::LIN_TAB[second_red];
      lin[4] <= rlcd_pkg::LIN_TAB[second_green];
      lin[5] <= rlcd_pkg::LIN_TAB[second_blue];
    end
  end

  logic [FW-1:0] fv [6];
  localparam logic [1:0] CH_SEL [3] = '{rlcd_pkg::CH_X, rlcd_pkg::CH_Y, rlcd_pkg::CH_Z};

  for (genvar p = 0; p < 2; p++) begin : g_pix
    for (genvar c = 0; c < 3; c++) begin : g_ch
      rlcd_chan u_chan (
        .clk   (clk),
        .en    (en),
        .lin_r (lin[3*p]),
        .lin_g (lin[3*p+1]),
        .lin_b (lin[3*p+2]),
        .sel   (CH_SEL[c]),
        .f     (fv[3*p+c])
      );
    end
  end

  // Lab deltas: L from Y, a from X-Y, b from Y-Z; magnitudes rounded to Q16.
  logic signed [22:0] dx, dy, dz;
  logic signed [23:0] dxy, dyz;
  logic signed [33:0] ml, ma, mb;
  logic [33:0] al, aa, ab;

  assign dx  = $signed({2'b00, fv[0]}) - $signed({2'b00, fv[3]});
  assign dy  = $signed({2'b00, fv[1]}) - $signed({2'b00, fv[4]});
  assign dz  = $signed({2'b00, fv[2]}) - $signed({2'b00, fv[5]});
  assign dxy = 24'(dx) - 24'(dy);
  assign dyz = 24'(dy) - 24'(dz);
  assign ml  = 34'(dy) * 34'sd116;
  assign ma  = 34'(dxy) * 34'sd500;
  assign mb  = 34'(dyz) * 34'sd200;
  assign al  = ml[33] ? 34'(-ml) : 34'(ml);
  assign aa  = ma[33] ? 34'(-ma) : 34'(ma);
  assign ab  = mb[33] ? 34'(-mb) : 34'(mb);

  logic [EW-1:0] el, ea, eb;
  logic [2*EW-1:0] sl, sa, sb;
  logic [SW-1:0] ssum;

  always_ff @(posedge clk) begin
    if (en) begin
      el <= EW'((al + 34'd8) >> 4);
      ea <= EW'((aa + 34'd8) >> 4);
      eb <= EW'((ab + 34'd8) >> 4);
      sl <= (2*EW)'(el) * (2*EW)'(el);
      sa <= (2*EW)'(ea) * (2*EW)'(ea);
      sb <= (2*EW)'(eb) * (2*EW)'(eb);
      ssum <= SW'(sl) + SW'(sa) + SW'(sb);
    end
  end

  // Square root one bit per stage, carrying the running square.
  logic [RW-1:0] sq_r   [RW];
  logic [SW-1:0] sq_r2  [RW];
  logic [SW-1:0] sq_tgt [RW];

  for (genvar j = 0; j < RW; j++) begin : g_sqrt
    localparam int K = RW - 1 - j;
    logic [RW-1:0] rin;
    logic [SW-1:0] r2in;
    logic [SW-1:0] tgin;
    logic [SW+1:0] cand;
    if (j == 0) begin : g_first
      assign rin  = '0;
      assign r2in = '0;
      assign tgin = ssum;
    end else begin : g_next
      assign rin  = sq_r[j-1];
      assign r2in = sq_r2[j-1];
      assign tgin = sq_tgt[j-1];
    end
    assign cand = (SW+2)'(r2in) + ((SW+2)'(rin) << (K + 1)) + ((SW+2)'(1) << (2 * K));
    always_ff @(posedge clk) begin
      if (en) begin
        sq_tgt[j] <= tgin;
        if (cand <= (SW+2)'(tgin)) begin
          sq_r[j]  <= rin | (RW'(1) << K);
          sq_r2[j] <= SW'(cand);
        end else begin
          sq_r[j]  <= rin;
          sq_r2[j] <= r2in;
        end
      end
    end
  end

  logic [RW:0] qr;
  if (rlcd_pkg::ROUND_SH > 0) begin : g_rnd
    assign qr = ((RW+1)'(sq_r[RW-1]) + ((RW+1)'(1) << (rlcd_pkg::ROUND_SH - 1)))
                >> rlcd_pkg::ROUND_SH;
  end else begin : g_nornd
    assign qr = (RW+1)'(sq_r[RW-1]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (qr > (RW+1)'(rlcd_pkg::OUT_MAX)) begin
        color_distance <= rlcd_pkg::OUT_MAX;
      end else begin
        color_distance <= rlcd_pkg::OUT_W'(qr);
      end
    end
  end

endmodule

// ===== rtl/core/rlcd_chan.sv =====
// One XYZ channel of one pixel: matrix row, white normalization and the CIE f function.
module rlcd_chan (
  input  logic                        clk,
  input  logic                        en,
  input  logic [rlcd_pkg::LIN_W-1:0]  lin_r,
  input  logic [rlcd_pkg::LIN_W-1:0]  lin_g,
  input  logic [rlcd_pkg::LIN_W-1:0]  lin_b,
  input  logic [1:0]                  sel,
  output logic [rlcd_pkg::F_W-1:0]    f
);

  localparam int CS  = rlcd_pkg::CUBE_STEPS;
  localparam int NW  = rlcd_pkg::NUM_W;
  localparam int TW  = rlcd_pkg::T_W;
  localparam int FW  = rlcd_pkg::F_W;
  localparam int LW  = rlcd_pkg::LN_W;
  localparam int RCW = rlcd_pkg::RECIP_W;

  // The channel select is tied off at the instance, so it needs no pipelining.
  logic [40:0] p0, p1, p2;
  logic [NW-1:0] num;

  always_ff @(posedge clk) begin
    if (en) begin
      p0 <= 41'(rlcd_pkg::MAT7[sel][0]) * 41'(lin_r);
      p1 <= 41'(rlcd_pkg::MAT7[sel][1]) * 41'(lin_g);
      p2 <= 41'(rlcd_pkg::MAT7[sel][2]) * 41'(lin_b);
      num <= ((NW'(p0) + NW'(p1) + NW'(p2)) << 4) + NW'(rlcd_pkg::WHITE_HALF[sel]);
    end
  end

  // Division by the white point as a reciprocal multiply, split into four partial
  // products in one stage and summed in the next.
  logic [RCW-1:0] recip;
  logic [21:0]    num_hi;
  logic [21:0]    num_lo;
  logic [21:0]    rc_hi;
  logic [22:0]    rc_lo;
  logic [44:0]    pp_hh, pp_hl, pp_lh, pp_ll;
  logic [89:0]    qsum;
  logic [TW-1:0]  t;

  assign recip  = rlcd_pkg::WHITE_RECIP[sel];
  assign num_hi = num[NW-1:22];
  assign num_lo = num[21:0];
  assign rc_hi  = recip[RCW-1:23];
  assign rc_lo  = recip[22:0];

  always_ff @(posedge clk) begin
    if (en) begin
      pp_hh <= 45'(num_hi) * 45'(rc_hi);
      pp_hl <= 45'(num_hi) * 45'(rc_lo);
      pp_lh <= 45'(num_lo) * 45'(rc_hi);
      pp_ll <= 45'(num_lo) * 45'(rc_lo);
    end
  end

  assign qsum = (90'(pp_hh) << 45) + (90'(pp_hl) << 22) + (90'(pp_lh) << 23) + 90'(pp_ll);

  always_ff @(posedge clk) begin
    if (en) begin
      t <= TW'(qsum >> rlcd_pkg::RECIP_SH);
    end
  end

  // Cube root one bit per stage, keeping r, r^2 and r^3 so each step is adds only.
  // The linear segment's division runs beside it over the same stages.
  logic [FW-1:0] cr_r   [CS];
  logic [41:0]   cr_r2  [CS];
  logic [63:0]   cr_r3  [CS];
  logic [61:0]   cr_tgt [CS];
  logic          cub    [CS];
  logic [LW-1:0] ln_num;
  logic [17:0]   ln_q   [1:CS-1];

  for (genvar j = 0; j < CS; j++) begin : g_f
    localparam int K = CS - 1 - j;
    logic [FW-1:0] rin;
    logic [41:0]   r2in;
    logic [63:0]   r3in;
    logic [61:0]   tgin;
    logic          cbin;
    logic [65:0]   cand3;
    logic [43:0]   cand2;
    if (j == 0) begin : g_first
      assign rin  = '0;
      assign r2in = '0;
      assign r3in = '0;
      assign tgin = {t, 40'd0};
      assign cbin = (t >= rlcd_pkg::F_KNEE);
    end else begin : g_next
      assign rin  = cr_r[j-1];
      assign r2in = cr_r2[j-1];
      assign r3in = cr_r3[j-1];
      assign tgin = cr_tgt[j-1];
      assign cbin = cub[j-1];
    end
    assign cand3 = 66'(r3in) + ((66'(r2in) * 66'd3) << K) + ((66'(rin) * 66'd3) << (2 * K))
                 + (66'd1 << (3 * K));
    assign cand2 = 44'(r2in) + (44'(rin) << (K + 1)) + (44'd1 << (2 * K));

    always_ff @(posedge clk) begin
      if (en) begin
        cr_tgt[j] <= tgin;
        cub[j]    <= cbin;
        if (cand3 <= 66'(tgin)) begin
          cr_r[j]  <= rin | (FW'(1) << K);
          cr_r2[j] <= 42'(cand2);
          cr_r3[j] <= 64'(cand3);
        end else begin
          cr_r[j]  <= rin;
          cr_r2[j] <= r2in;
          cr_r3[j] <= r3in;
        end
      end
    end

    if (j == 0) begin : g_lnum
      logic [35:0] prod;
      assign prod = 36'(rlcd_pkg::LIN_MUL) * 36'(t);
      always_ff @(posedge clk) begin
        if (en) begin
          ln_num <= LW'(prod) + rlcd_pkg::LIN_ADD;
        end
      end
    end else if (j == 1) begin : g_ldiv
      logic [56:0] lprod;
      assign lprod = 57'(ln_num) * 57'(rlcd_pkg::LIN_RECIP);
      always_ff @(posedge clk) begin
        if (en) begin
          ln_q[j] <= 18'(lprod >> rlcd_pkg::LIN_RECIP_SH);
        end
      end
    end else begin : g_lhold
      always_ff @(posedge clk) begin
        if (en) begin
          ln_q[j] <= ln_q[j-1];
        end
      end
    end
  end

  assign f = cub[CS-1] ? cr_r[CS-1] : FW'(ln_q[CS-1]);

endmodule
